// File: design/sfps_pkg.sv
`timescale 1ns / 1ps
package sfps_pkg;

	// One second in nanoseconds; also the widest camera interval
	localparam int unsigned STEP_W = 30;
	localparam logic [STEP_W-1:0] NS_PER_S = 30'd1000000000;

	localparam int unsigned TS_W   = 63;
	localparam int unsigned RATE_W = 10;
	localparam int unsigned CNT_W  = 32;
	localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

	// Result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_CLOCK_RESET = 2'd1;
	localparam logic [1:0] ST_TIMEOUT     = 2'd2;
	localparam logic [1:0] ST_UNHEALTHY   = 2'd3;

	// Action codes
	localparam logic ACT_QUERY  = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	typedef struct packed {
		logic              action;
		logic [CNT_W-1:0]  reset_count;
		logic [RATE_W-1:0] target_fps;
		logic              grabbed;
		logic              camera_healthy;
		logic [TS_W-1:0]   left_timestamp;
		logic [TS_W-1:0]   right_timestamp;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [TS_W-1:0]   min_timestamp;
		logic [TS_W-1:0]   capture_timestamp;
		logic [TS_W-1:0]   logical_timestamp;
		logic [STEP_W-1:0] frame_step;
		logic [CNT_W-1:0]  frame_id;
	} out_beat_t;

	// Divider control and status
	typedef struct packed {
		logic start;
		logic wide;   // 64-bit dividend; else 30-bit dividend
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

endpackage

// File: design/sfps_if.sv
`timescale 1ns / 1ps
interface sfps_in_if;
	import sfps_pkg::*;
	logic     valid;
	logic     ready;
	in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfps_out_if;
	import sfps_pkg::*;
	logic      valid;
	logic      ready;
	out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/stereo_frame_pacing_scheduler_unit.sv
`timescale 1ns / 1ps
// A clock reset, a grab failure or an unscheduled query is answered without division. A query
// divides for the camera interval and, to reschedule, for the target interval; a successful
// grab divides for both and may add the schedule catch-up division. All of them use the shared
// restoring divider, one bit per cycle: 30-bit dividends for the intervals, 64-bit for catch-up.
// One item at a time; the next beat is taken once the result sits in the output register.
// Reset (arst_n, asynchronous): camera rate 30, all timeline state and frame id cleared.
module stereo_frame_pacing_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	sfps_in_if.sink     req,
	sfps_out_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sfps_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_STEP,
		S_LOGIC,
		S_IV,
		S_SCHED,
		S_ADV,
		S_MIN,
		S_DONE
	} state_t;

	state_t            state_q;

	logic [RATE_W-1:0] cfg_rate;
	logic [RATE_W-1:0] cam_rate;
	logic [RATE_W-1:0] clamp_rate;

	// Item registers
	in_beat_t          in_q;
	logic [TS_W-1:0]   cap_q;
	logic [RATE_W-1:0] rate_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] iv_q;
	logic [63:0]       adj_q;
	logic [63:0]       adjiv_q;
	out_beat_t         res_q;

	// Timeline state
	logic              seen_q;
	logic [CNT_W-1:0]  last_cnt_q;
	logic [TS_W-1:0]   last_log_q;
	logic [TS_W-1:0]   last_cap_q;
	logic [63:0]       next_q;
	logic [RATE_W-1:0] sched_rate_q;
	logic [CNT_W-1:0]  frame_num_q;

	// Output register
	out_beat_t         out_q;
	logic              out_valid_q;

	// Divider port
	div_req_t          div_req_q;
	div_rsp_t          div_rsp;
	logic [63:0]       div_num_q;
	logic [STEP_W-1:0] div_den_q;
	logic [63:0]       div_quo;
	logic [STEP_W-1:0] div_rem;

	logic [63:0]       mid_sum;
	logic [26:0]       tol;
	logic              resched;
	logic [63:0]       log_sum;
	logic [TS_W-1:0]   log_val;
	logic [63:0]       min_diff;
	logic [TS_W-1:0]   min_val;

	sfps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cam_rate (cfg_rate)
	);

	sfps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.rsp    (div_rsp),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Rate clamp and midpoint at the input
	always_comb begin
		cam_rate   = (cfg_rate == '0) ? {{(RATE_W-1){1'b0}}, 1'b1} : cfg_rate;
		clamp_rate = (req.data.target_fps == '0 || req.data.target_fps > cam_rate) ?
			cam_rate : req.data.target_fps;
		mid_sum    = {1'b0, req.data.left_timestamp} + {1'b0, req.data.right_timestamp};
	end

	// Tolerance: one eighth of a camera interval, at least 1 ns
	always_comb begin
		tol     = (step_q[STEP_W-1:3] == '0) ? 27'd1 : step_q[STEP_W-1:3];
		resched = (sched_rate_q != rate_q) || (next_q == 64'd0);
	end

	// Monotonic logical time
	always_comb begin
		log_sum = {1'b0, last_log_q} + {{(64-STEP_W){1'b0}}, step_q};
		if (last_log_q != '0 && cap_q <= last_log_q) begin
			log_val = log_sum[63] ? TS_MAX : log_sum[TS_W-1:0];
		end else begin
			log_val = cap_q;
		end
	end

	// Minimum timestamp from the schedule
	always_comb begin
		min_diff = (next_q > {37'd0, tol}) ? next_q - {37'd0, tol} : 64'd0;
		min_val  = min_diff[63] ? TS_MAX : min_diff[TS_W-1:0];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			in_q         <= '0;
			cap_q        <= '0;
			rate_q       <= '0;
			step_q       <= '0;
			iv_q         <= '0;
			adj_q        <= '0;
			adjiv_q      <= '0;
			res_q        <= '0;
			seen_q       <= 1'b0;
			last_cnt_q   <= '0;
			last_log_q   <= '0;
			last_cap_q   <= '0;
			next_q       <= '0;
			sched_rate_q <= '0;
			frame_num_q  <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			div_req_q    <= '0;
			div_num_q    <= '0;
			div_den_q    <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						in_q    <= req.data;
						cap_q   <= mid_sum[TS_W:1];
						rate_q  <= clamp_rate;
						state_q <= S_CHECK;
					end
				end

				S_CHECK: begin
					res_q <= '0;
					priority if (seen_q && in_q.reset_count != last_cnt_q) begin
						// camera clock reset: clear the timeline
						last_cnt_q     <= in_q.reset_count;
						last_log_q     <= '0;
						last_cap_q     <= '0;
						next_q         <= '0;
						sched_rate_q   <= '0;
						res_q.status   <= ST_CLOCK_RESET;
						state_q        <= S_DONE;
					end else if (in_q.action == ACT_REPORT && !in_q.grabbed) begin
						res_q.status   <= in_q.camera_healthy ? ST_TIMEOUT : ST_UNHEALTHY;
						state_q        <= S_DONE;
					end else if (in_q.action == ACT_QUERY && last_cap_q == '0) begin
						res_q.status   <= ST_OK;
						state_q        <= S_DONE;
					end else begin
						// camera interval first
						div_req_q.start <= 1'b1;
						div_req_q.wide  <= 1'b0;
						div_num_q       <= {{(64-STEP_W){1'b0}}, NS_PER_S};
						div_den_q       <= {{(STEP_W-RATE_W){1'b0}}, cam_rate};
						state_q         <= S_STEP;
					end
					if (!seen_q) begin
						seen_q     <= 1'b1;
						last_cnt_q <= in_q.reset_count;
					end
				end

				S_STEP: begin
					if (div_rsp.done) begin
						step_q <= div_quo[STEP_W-1:0];
						if (in_q.action == ACT_REPORT) begin
							state_q <= S_LOGIC;
						end else if (resched) begin
							div_req_q.start <= 1'b1;
							div_req_q.wide  <= 1'b0;
							div_den_q       <= {{(STEP_W-RATE_W){1'b0}}, rate_q};
							state_q         <= S_IV;
						end else begin
							state_q <= S_MIN;
						end
					end
				end

				S_LOGIC: begin
					last_log_q              <= log_val;
					last_cap_q              <= cap_q;
					res_q.status            <= ST_OK;
					res_q.capture_timestamp <= cap_q;
					res_q.logical_timestamp <= log_val;
					res_q.frame_step        <= step_q;
					res_q.frame_id          <= frame_num_q;
					frame_num_q             <= frame_num_q + 32'd1;
					div_req_q.start         <= 1'b1;
					div_req_q.wide          <= 1'b0;
					div_den_q               <= {{(STEP_W-RATE_W){1'b0}}, rate_q};
					state_q                 <= S_IV;
				end

				S_IV: begin
					if (div_rsp.done) begin
						iv_q <= div_quo[STEP_W-1:0];
						if (in_q.action == ACT_QUERY) begin
							sched_rate_q <= rate_q;
							next_q       <= {1'b0, last_cap_q} +
								{{(64-STEP_W){1'b0}}, div_quo[STEP_W-1:0]};
							state_q      <= S_MIN;
						end else if (resched) begin
							sched_rate_q <= rate_q;
							next_q       <= {1'b0, cap_q} +
								{{(64-STEP_W){1'b0}}, div_quo[STEP_W-1:0]};
							state_q      <= S_DONE;
						end else begin
							adj_q   <= {1'b0, cap_q} + {37'd0, tol};
							state_q <= S_SCHED;
						end
					end
				end

				S_SCHED: begin
					// catch up by whole intervals: next = adj - (adj - next) % iv + iv
					if (adj_q >= next_q) begin
						div_req_q.start <= 1'b1;
						div_req_q.wide  <= 1'b1;
						div_num_q       <= adj_q - next_q;
						div_den_q       <= iv_q;
						adjiv_q         <= adj_q + {{(64-STEP_W){1'b0}}, iv_q};
						state_q         <= S_ADV;
					end else begin
						state_q <= S_DONE;
					end
				end

				S_ADV: begin
					if (div_rsp.done) begin
						next_q  <= adjiv_q - {{(64-STEP_W){1'b0}}, div_rem};
						state_q <= S_DONE;
					end
				end

				S_MIN: begin
					res_q.status        <= ST_OK;
					res_q.min_timestamp <= min_val;
					state_q             <= S_DONE;
				end

				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

// File: design/sfps_cfg.sv
`timescale 1ns / 1ps
module sfps_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [sfps_pkg::RATE_W-1:0] cam_rate
);
	import sfps_pkg::*;

	localparam logic [RATE_W-1:0] CAM_RATE_RST = 10'd30;

	logic [RATE_W-1:0] cam_rate_q;
	logic              sel_rate;

	// Register 0 occupies the word at byte address 0
	assign sel_rate = (paddr[2] == 1'b0);
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_rate_q <= CAM_RATE_RST;
		end else if (psel && penable && pwrite && sel_rate) begin
			cam_rate_q <= pwdata[RATE_W-1:0];
		end
	end

	assign prdata   = sel_rate ? {{(32-RATE_W){1'b0}}, cam_rate_q} : 32'd0;
	assign cam_rate = cam_rate_q;

endmodule

// File: design/sfps_div.sv
`timescale 1ns / 1ps
module sfps_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfps_pkg::div_req_t          req,
	input  logic [63:0]                 num,
	input  logic [sfps_pkg::STEP_W-1:0] den,
	output sfps_pkg::div_rsp_t          rsp,
	output logic [63:0]                 quo,
	output logic [sfps_pkg::STEP_W-1:0] rem
);
	import sfps_pkg::*;

	localparam logic [6:0] WIDE_STEPS   = 7'd64;
	localparam logic [6:0] NARROW_STEPS = 7'd30;

	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] den_q;
	logic [63:0]       quo_q;
	logic [6:0]        cnt_q;
	logic              done_q;

	logic [STEP_W:0]   shifted;
	logic [STEP_W+1:0] diff;
	logic              geq;

	// Restoring divide, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[63]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		geq     = ~diff[STEP_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			rem_q  <= '0;
			den_q  <= den;
			// narrow dividend is left aligned so its MSB leads
			quo_q  <= req.wide ? num : {num[STEP_W-1:0], {(64-STEP_W){1'b0}}};
			cnt_q  <= req.wide ? WIDE_STEPS : NARROW_STEPS;
			done_q <= 1'b0;
		end else if (cnt_q != 7'd0) begin
			rem_q  <= geq ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
			quo_q  <= {quo_q[62:0], geq};
			cnt_q  <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.busy = (cnt_q != 7'd0);
	assign rsp.done = done_q;
	assign quo      = quo_q;
	assign rem      = rem_q;

endmodule

// File: dv/stereo_frame_pacing_scheduler_unit_test.sv
`timescale 1ns / 1ps
module stereo_frame_pacing_scheduler_unit_test;
	import sfps_pkg::*;

	localparam int unsigned CLK_HALF       = 6;
	localparam int unsigned RESET_CYCLES   = 7;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES   = 200;
	localparam int unsigned PHASES         = 8;
	localparam int unsigned PHASE_ITEMS    = 250;
	localparam int unsigned REPORT_LIMIT   = 10;
	localparam logic [2:0]  ADDR_CAMERA_RATE = 3'd0;
	localparam logic [RATE_W-1:0] CAMERA_RATE_RESET = 10'd30;
	// camera rate per phase; phases 3 and 5 pick a random rate instead
	localparam logic [RATE_W-1:0] RATE_PLAN [PHASES] = '{
		10'd0, 10'd1023, 10'd1, 10'd0, 10'd30, 10'd0, 10'd1023, 10'd0
	};

	typedef struct {
		in_beat_t  beat;
		bit        typed;
		out_beat_t want;
	} probe_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sfps_in_if  req_ch ();
	sfps_out_if rsp_ch ();

	stereo_frame_pacing_scheduler_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(CLK_HALF) clk = ~clk;

	// Scheduler state as the block should hold it
	logic [RATE_W-1:0] cam_fps = CAMERA_RATE_RESET;
	logic              sc_clock_seen = 1'b0;
	logic [CNT_W-1:0]  sc_last_count = '0;
	logic [63:0]       sc_last_logical = '0;
	logic [63:0]       sc_last_capture = '0;
	logic [63:0]       sc_next_due = '0;
	logic [RATE_W-1:0] sc_sched_rate = '0;
	logic [CNT_W-1:0]  sc_frame_no = '0;

	out_beat_t   pending_results [$];
	probe_t      probes [$];
	int unsigned mismatch_cnt = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 27;
	int unsigned recv_idle_pct = 49;

	function automatic logic [63:0] cam_rate();
		return (cam_fps == '0) ? 64'd1 : 64'(cam_fps);
	endfunction

	function automatic logic [63:0] cam_interval();
		return 64'(NS_PER_S) / cam_rate();
	endfunction

	// schedule tolerance: an eighth of a camera interval, at least 1 ns
	function automatic logic [63:0] sched_slack();
		logic [63:0] t;
		t = cam_interval() / 64'd8;
		return (t == '0) ? 64'd1 : t;
	endfunction

	function automatic logic [TS_W-1:0] wide_rand();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[TS_W-1:0];
	endfunction

	function automatic out_beat_t schedule_result(in_beat_t b);
		out_beat_t   r;
		logic [63:0] pace, iv, tol, lo, hi, cap, logical, adj, m, step;
		r = '0;
		pace = (b.target_fps == '0 || 64'(b.target_fps) > cam_rate()) ? cam_rate()
			: 64'(b.target_fps);
		// camera clock reset check; the first count seen is just recorded
		if (!sc_clock_seen) begin
			sc_clock_seen = 1'b1;
			sc_last_count = b.reset_count;
		end else if (b.reset_count != sc_last_count) begin
			sc_last_count = b.reset_count;
			sc_last_logical = '0;
			sc_last_capture = '0;
			sc_next_due = '0;
			sc_sched_rate = '0;
			r.status = ST_CLOCK_RESET;
			return r;
		end
		// query: earliest capture time, zero while no frame has been taken
		if (b.action == ACT_QUERY) begin
			r.status = ST_OK;
			if (sc_last_capture != '0) begin
				if (64'(sc_sched_rate) != pace || sc_next_due == '0) begin
					sc_sched_rate = pace[RATE_W-1:0];
					sc_next_due = sc_last_capture + 64'(NS_PER_S) / pace;
				end
				tol = sched_slack();
				m = (sc_next_due > tol) ? sc_next_due - tol : 64'd0;
				r.min_timestamp = (m > 64'(TS_MAX)) ? TS_MAX : m[TS_W-1:0];
			end
			return r;
		end
		if (!b.grabbed) begin
			r.status = b.camera_healthy ? ST_TIMEOUT : ST_UNHEALTHY;
			return r;
		end
		// grab success: midpoint capture, monotonic logical time
		iv = 64'(NS_PER_S) / pace;
		step = cam_interval();
		lo = (b.left_timestamp < b.right_timestamp) ? 64'(b.left_timestamp)
			: 64'(b.right_timestamp);
		hi = (b.left_timestamp < b.right_timestamp) ? 64'(b.right_timestamp)
			: 64'(b.left_timestamp);
		cap = lo + (hi - lo) / 64'd2;
		logical = cap;
		if (sc_last_logical != '0 && logical <= sc_last_logical) begin
			logical = sc_last_logical + step;
			if (logical > 64'(TS_MAX))
				logical = 64'(TS_MAX);
		end
		sc_last_logical = logical;
		sc_last_capture = cap;
		r.status = ST_OK;
		r.capture_timestamp = cap[TS_W-1:0];
		r.logical_timestamp = logical[TS_W-1:0];
		r.frame_step = step[STEP_W-1:0];
		r.frame_id = sc_frame_no;
		sc_frame_no = sc_frame_no + 1'b1;
		// move the schedule forward by whole intervals
		if (64'(sc_sched_rate) != pace || sc_next_due == '0) begin
			sc_sched_rate = pace[RATE_W-1:0];
			sc_next_due = cap + iv;
		end else begin
			adj = cap + sched_slack();
			if (adj >= sc_next_due)
				sc_next_due = sc_next_due + ((adj - sc_next_due) / iv + 64'd1) * iv;
		end
		return r;
	endfunction

	function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_LIMIT)
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
	endfunction

	function automatic in_beat_t ask(logic [CNT_W-1:0] cnt, logic [RATE_W-1:0] fps);
		in_beat_t b;
		b = '0;
		b.action = ACT_QUERY;
		b.reset_count = cnt;
		b.target_fps = fps;
		return b;
	endfunction

	function automatic in_beat_t tell(logic [CNT_W-1:0] cnt, logic [RATE_W-1:0] fps,
			logic grabbed, logic healthy, logic [TS_W-1:0] lt, logic [TS_W-1:0] rt);
		in_beat_t b;
		b.action = ACT_REPORT;
		b.reset_count = cnt;
		b.target_fps = fps;
		b.grabbed = grabbed;
		b.camera_healthy = healthy;
		b.left_timestamp = lt;
		b.right_timestamp = rt;
		return b;
	endfunction

	function automatic out_beat_t result_of(logic [1:0] status, logic [TS_W-1:0] min_ts,
			logic [TS_W-1:0] cap, logic [TS_W-1:0] logical, logic [STEP_W-1:0] step,
			logic [CNT_W-1:0] id);
		out_beat_t r;
		r.status = status;
		r.min_timestamp = min_ts;
		r.capture_timestamp = cap;
		r.logical_timestamp = logical;
		r.frame_step = step;
		r.frame_id = id;
		return r;
	endfunction

	function automatic void add_probe(in_beat_t b, bit typed, out_beat_t w);
		probe_t p;
		p.beat = b;
		p.typed = typed;
		p.want = w;
		probes.push_back(p);
	endfunction

	// Offer one beat; the expected result is queued when it is taken
	task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
		out_beat_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= b;
		do @(posedge clk); while (!req_ch.ready);
		predicted = schedule_result(b);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// APB transfer; psel stays high so a second transfer may follow at once
	task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic check_camera_rate();
		logic [31:0] rd;
		apb_xfer(1'b0, ADDR_CAMERA_RATE, '0, rd);
		if (rd !== 32'(cam_fps))
			flag_mismatch("camera rate readback", 64'(cam_fps), 64'(rd));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_camera_rate(logic [RATE_W-1:0] v);
		logic [31:0] rd;
		apb_xfer(1'b1, ADDR_CAMERA_RATE, 32'(v), rd);
		cam_fps = v;
		check_camera_rate();
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random backpressure, compare each beat with the oldest expectation
	always @(posedge clk) begin
		out_beat_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unrequested result beat, status", '0, 64'(rsp_ch.data.status));
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.data.status !== want.status)
					flag_mismatch("status", 64'(want.status), 64'(rsp_ch.data.status));
				if (rsp_ch.data.min_timestamp !== want.min_timestamp)
					flag_mismatch("min_timestamp", 64'(want.min_timestamp),
						64'(rsp_ch.data.min_timestamp));
				if (rsp_ch.data.capture_timestamp !== want.capture_timestamp)
					flag_mismatch("capture_timestamp", 64'(want.capture_timestamp),
						64'(rsp_ch.data.capture_timestamp));
				if (rsp_ch.data.logical_timestamp !== want.logical_timestamp)
					flag_mismatch("logical_timestamp", 64'(want.logical_timestamp),
						64'(rsp_ch.data.logical_timestamp));
				if (rsp_ch.data.frame_step !== want.frame_step)
					flag_mismatch("frame_step", 64'(want.frame_step),
						64'(rsp_ch.data.frame_step));
				if (rsp_ch.data.frame_id !== want.frame_id)
					flag_mismatch("frame_id", 64'(want.frame_id), 64'(rsp_ch.data.frame_id));
			end
		end
		if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: too long without any beat moving
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int unsigned       phase, sent, roll;
		logic [CNT_W-1:0]  live_cnt;
		logic [RATE_W-1:0] live_fps;
		logic [63:0]       clock_ts;
		logic [TS_W-1:0]   lt, rt;
		in_beat_t          beat;

		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_camera_rate();

		// Directed probes at the reset camera rate of 30 fps
		add_probe(ask(32'd5, 10'd0), 1'b1, result_of(ST_OK, '0, '0, '0, '0, '0));
		add_probe(tell(32'd5, 10'd0, 1'b0, 1'b1, '0, '0), 1'b1,
			result_of(ST_TIMEOUT, '0, '0, '0, '0, '0));
		add_probe(tell(32'd5, 10'd0, 1'b0, 1'b0, TS_MAX, TS_MAX), 1'b1,
			result_of(ST_UNHEALTHY, '0, '0, '0, '0, '0));
		add_probe(tell(32'd5, 10'd0, 1'b1, 1'b1, 63'd1000, 63'd3000), 1'b1,
			result_of(ST_OK, '0, 63'd2000, 63'd2000, STEP_W'(NS_PER_S / 30), '0));
		add_probe(ask(32'd5, 10'd0), 1'b0, '0);
		add_probe(ask(32'd5, 10'd1023), 1'b0, '0);
		add_probe(ask(32'd5, 10'd10), 1'b0, '0);
		// capture behind the logical time forces one camera step
		add_probe(tell(32'd5, 10'd10, 1'b1, 1'b1, 63'd1500, 63'd1500), 1'b0, '0);
		add_probe(tell(32'd5, 10'd10, 1'b1, 1'b0, TS_MAX, TS_MAX - 63'd10), 1'b0, '0);
		add_probe(tell(32'd5, 10'd10, 1'b1, 1'b1, TS_MAX, TS_MAX), 1'b0, '0);
		// logical time saturates
		add_probe(tell(32'd5, 10'd10, 1'b1, 1'b1, '0, '0), 1'b0, '0);
		add_probe(tell(32'd5, 10'd10, 1'b1, 1'b1, TS_MAX, TS_MAX), 1'b0, '0);
		// minimum timestamp saturates
		add_probe(ask(32'd5, 10'd1), 1'b1, result_of(ST_OK, TS_MAX, '0, '0, '0, '0));
		add_probe(ask(32'd6, 10'd0), 1'b1, result_of(ST_CLOCK_RESET, '0, '0, '0, '0, '0));
		add_probe(ask(32'd6, 10'd0), 1'b1, result_of(ST_OK, '0, '0, '0, '0, '0));
		add_probe(tell(32'd7, 10'd0, 1'b0, 1'b1, '0, '0), 1'b1,
			result_of(ST_CLOCK_RESET, '0, '0, '0, '0, '0));
		add_probe(tell(32'd7, 10'd1023, 1'b1, 1'b0, '0, TS_MAX), 1'b0, '0);
		add_probe(ask(32'd7, 10'd7), 1'b0, '0);
		add_probe(ask(32'd0, 10'd1023), 1'b1, result_of(ST_CLOCK_RESET, '0, '0, '0, '0, '0));
		add_probe(tell(32'hFFFF_FFFF, 10'd0, 1'b0, 1'b0, '0, '0), 1'b1,
			result_of(ST_CLOCK_RESET, '0, '0, '0, '0, '0));
		add_probe(tell(32'hFFFF_FFFF, 10'd0, 1'b0, 1'b0, '0, '0), 1'b1,
			result_of(ST_UNHEALTHY, '0, '0, '0, '0, '0));
		add_probe(ask(32'hFFFF_FFFF, 10'd1023), 1'b1, result_of(ST_OK, '0, '0, '0, '0, '0));
		add_probe(tell(32'hFFFF_FFFF, 10'd0, 1'b1, 1'b1, 63'd2, 63'd5), 1'b0, '0);
		add_probe(ask(32'hFFFF_FFFF, 10'd0), 1'b0, '0);
		foreach (probes[i])
			send_beat(probes[i].beat, probes[i].typed, probes[i].want);
		req_ch.valid <= 1'b0;

		// Random phases: mostly query/report pairs on a moving timeline, some noise
		live_cnt = 32'hFFFF_FFFF;
		live_fps = '0;
		clock_ts = 64'($urandom());
		for (phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			set_camera_rate((phase == 3 || phase == 5) ? RATE_W'($urandom_range(2, 1022))
				: RATE_PLAN[phase]);
			if (phase * 3 / PHASES == 0) begin
				send_idle_pct = 27;
				recv_idle_pct = 49;
			end else if (phase * 3 / PHASES == 1) begin
				send_idle_pct = 49;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				if (roll < 10) begin
					// lone beat with random content
					beat.action = 1'($urandom_range(1));
					beat.reset_count = ($urandom_range(4) == 0) ? $urandom() : live_cnt;
					beat.target_fps = RATE_W'($urandom());
					beat.grabbed = 1'($urandom_range(1));
					beat.camera_healthy = 1'($urandom_range(1));
					beat.left_timestamp = wide_rand();
					beat.right_timestamp = wide_rand();
					send_beat(beat, 1'b0, '0);
					sent++;
				end else begin
					if ($urandom_range(99) < 4)
						live_cnt = $urandom_range(1) ? live_cnt + 1'b1 : $urandom();
					if ($urandom_range(99) < 10)
						live_fps = ($urandom_range(3) == 0) ? '0 : RATE_W'($urandom());
					clock_ts = clock_ts + cam_interval() * $urandom_range(4) / 2
						+ $urandom_range(200000);
					roll = $urandom_range(99);
					if (roll < 3)
						clock_ts = 64'(TS_MAX) - 64'($urandom_range(32'd3000000000));
					else if (roll < 6)
						clock_ts = clock_ts - ((clock_ts > 64'd2000000000) ?
							64'($urandom_range(32'd2000000000)) : clock_ts);
					if (roll >= 6 && roll < 9) begin
						lt = wide_rand();
						rt = wide_rand();
					end else begin
						lt = TS_W'(clock_ts + $urandom_range(50000));
						rt = TS_W'(clock_ts + $urandom_range(50000));
					end
					send_beat(ask(live_cnt, live_fps), 1'b0, '0);
					send_beat(tell(live_cnt, live_fps, $urandom_range(99) < 88,
						1'($urandom_range(1)), lt, rt), 1'b0, '0);
					sent += 2;
					if (clock_ts > 64'(TS_MAX) - (64'd1 << 40))
						clock_ts = 64'($urandom());
				end
			end
			req_ch.valid <= 1'b0;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
